// File: hw/rtl/eth_ipv4_l4_header_parser_macros.svh
// Assertion macros shared by the header parser RTL.
`ifndef ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define HP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define HP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ip4hp_pkg.sv
// Types, constants and helpers for the Ethernet/IPv4/L4 header parser.
package ip4hp_pkg;

  localparam int MAX_PACKET_BYTES = 16384;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int FIELD14_MAX      = 16383;

  localparam int ETH_HDR_BYTES = 14;
  localparam int MIN_HDR_BYTES = 20;
  localparam int UDP_HDR_BYTES = 8;
  localparam int ETYPE_POS_HI  = 12;
  localparam int ETYPE_POS_LO  = 13;
  localparam int IP_PROTO_OFS  = 9;
  localparam int IP_SRC_OFS    = 12;
  localparam int IP_DST_OFS    = 16;
  localparam int IP_ADDR_END   = 20;
  localparam int L4_DPORT_OFS  = 2;
  localparam int L4_PORT_END   = 4;
  localparam int TCP_DOFF_OFS  = 12;

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] IPV4_KIND = 16'h0800;

  // Configuration register indexes (byte address / 4).
  localparam logic REG_LINK_TYPE = 1'b0;

  localparam logic LINK_ETH = 1'b0;

  typedef enum logic [3:0] {
    ST_TCP         = 4'd0,
    ST_UDP         = 4'd1,
    ST_OTHER_IPV4  = 4'd2,
    ST_TRUNCATED   = 4'd3,
    ST_SHORT_FRAME = 4'd4,
    ST_NOT_IPV4    = 4'd5,
    ST_BAD_IHL     = 4'd6,
    ST_L4_SHORT    = 4'd7,
    ST_BAD_DOFF    = 4'd8,
    ST_NOT_TCP_RAW = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       truncated;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [13:0] payload_offset;
    logic [13:0] payload_length;
  } result_t;

  // Clamp a signed offset or length into the 14-bit result field.
  function automatic logic [13:0] sat14(input logic signed [POS_W:0] v);
    logic [13:0] r;
    if (v < 0) begin
      r = '0;
    end else if (int'(v) > FIELD14_MAX) begin
      r = 14'(FIELD14_MAX);
    end else begin
      r = 14'(v);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/eth_ipv4_l4_header_parser.sv
// Ethernet/IPv4 TCP/UDP header parser: byte-stream capture and result queue.
//
// Usage:
//  - item channel (item_valid/item_ready/item): one packet byte per request in
//    wire order, last_byte marks the final byte, truncated is read with it.
//  - result channel (result_valid/result_ready/result): one result per packet,
//    produced by the request carrying last_byte; other bytes produce nothing.
//  - APB port sets link_type (0 Ethernet with 14-byte link header, 1 raw IPv4).
//    Write it only while no packet is in flight.
// Timing:
//  - One byte accepted every cycle while the skid entry is empty. Header
//    fields are captured by fixed offset compares against the running byte
//    position; status, offsets and lengths come out of one combinational pass.
//  - The result is registered: output register, or skid while output stalls.
// Stall:
//  - A two-entry result queue (output register plus skid) lets the parser keep
//    taking bytes while a result waits; item_ready drops only when both entries
//    are full.
// Reset (rst, synchronous): link_type = Ethernet, packet state cleared,
//  result queue empty.
`include "eth_ipv4_l4_header_parser_macros.svh"

module eth_ipv4_l4_header_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ip4hp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output ip4hp_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ip4hp_pkg::*;

  // Configuration
  logic link_type;

  // Per-packet capture state
  logic [POS_W-1:0] pos;
  logic [15:0]      ether_kind;
  logic [3:0]       ip_header_words;
  logic [7:0]       ip_protocol;
  logic [31:0]      held_source_ip;
  logic [31:0]      held_dest_ip;
  logic [15:0]      held_src_port;
  logic [15:0]      held_dst_port;
  logic [3:0]       tcp_offset_words;

  // Result queue
  result_t skid;
  logic    skid_valid;

  // Next-state values (with this byte folded in)
  logic [POS_W-1:0] pos_next;
  logic [15:0]      ether_kind_next;
  logic [3:0]       ip_header_words_next;
  logic [7:0]       ip_protocol_next;
  logic [31:0]      held_source_ip_next;
  logic [31:0]      held_dest_ip_next;
  logic [15:0]      held_src_port_next;
  logic [15:0]      held_dst_port_next;
  logic [3:0]       tcp_offset_words_next;

  logic                    eth;
  logic [POS_W-1:0]        base;
  logic [POS_W-1:0]        l4;
  logic [5:0]              size_ip;
  logic [5:0]              tcp_hdr_len;
  logic signed [POS_W:0]   rem;
  logic signed [POS_W:0]   off_tcp;
  logic signed [POS_W:0]   off_udp;
  logic signed [POS_W:0]   off_ip;
  logic signed [POS_W:0]   plen_tcp;
  logic signed [POS_W:0]   plen_udp;
  logic                    accept;
  logic                    cfg_write;
  result_t                 res;

  assign accept    = item_valid && item_ready;
  assign item_ready = !skid_valid;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_LINK_TYPE) ? {31'd0, link_type} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= LINK_ETH;
    end else if (cfg_write && paddr[2] == REG_LINK_TYPE) begin
      link_type <= pwdata[0];
    end
  end

  // ---- Field capture: each byte is compared against its fixed offset ----
  always_comb begin
    eth  = (link_type == LINK_ETH);
    base = eth ? POS_W'(ETH_HDR_BYTES) : '0;

    ether_kind_next = ether_kind;
    if (pos == POS_W'(ETYPE_POS_HI) || pos == POS_W'(ETYPE_POS_LO)) begin
      ether_kind_next = {ether_kind[7:0], item.data_byte};
    end

    ip_header_words_next = ip_header_words;
    if (pos == base) begin
      ip_header_words_next = item.data_byte[3:0];
    end

    ip_protocol_next = ip_protocol;
    if (pos == base + POS_W'(IP_PROTO_OFS)) begin
      ip_protocol_next = item.data_byte;
    end

    held_source_ip_next = held_source_ip;
    if (pos >= base + POS_W'(IP_SRC_OFS) && pos < base + POS_W'(IP_DST_OFS)) begin
      held_source_ip_next = {held_source_ip[23:0], item.data_byte};
    end

    held_dest_ip_next = held_dest_ip;
    if (pos >= base + POS_W'(IP_DST_OFS) && pos < base + POS_W'(IP_ADDR_END)) begin
      held_dest_ip_next = {held_dest_ip[23:0], item.data_byte};
    end

    // Transport header start uses the IHL including this byte.
    size_ip = {ip_header_words_next, 2'b00};
    l4      = base + POS_W'(size_ip);

    held_src_port_next = held_src_port;
    if (pos >= l4 && pos < l4 + POS_W'(L4_DPORT_OFS)) begin
      held_src_port_next = {held_src_port[7:0], item.data_byte};
    end

    held_dst_port_next = held_dst_port;
    if (pos >= l4 + POS_W'(L4_DPORT_OFS) && pos < l4 + POS_W'(L4_PORT_END)) begin
      held_dst_port_next = {held_dst_port[7:0], item.data_byte};
    end

    tcp_offset_words_next = tcp_offset_words;
    if (pos == l4 + POS_W'(TCP_DOFF_OFS)) begin
      tcp_offset_words_next = item.data_byte[7:4];
    end

    // Byte count saturates at the maximum packet size.
    pos_next = (int'(pos) < MAX_PACKET_BYTES) ? pos + 1'b1 : pos;
  end

  // ---- Result for a last byte ----
  always_comb begin
    tcp_hdr_len = {tcp_offset_words_next, 2'b00};
    rem      = $signed({1'b0, pos_next}) - $signed({1'b0, l4});
    off_ip   = $signed({1'b0, l4});
    off_tcp  = off_ip + $signed((POS_W + 1)'(tcp_hdr_len));
    off_udp  = off_ip + $signed((POS_W + 1)'(UDP_HDR_BYTES));
    plen_tcp = rem - $signed((POS_W + 1)'(tcp_hdr_len));
    plen_udp = rem - $signed((POS_W + 1)'(UDP_HDR_BYTES));

    res                = '0;
    res.status         = ST_TCP;
    res.source_ip      = held_source_ip_next;
    res.dest_ip        = held_dest_ip_next;

    if (item.truncated) begin
      res = '0;
      res.status = ST_TRUNCATED;
    end else if (eth && int'(pos_next) < ETH_HDR_BYTES) begin
      res = '0;
      res.status = ST_SHORT_FRAME;
    end else if (eth && ether_kind_next != IPV4_KIND) begin
      res = '0;
      res.status = ST_NOT_IPV4;
    end else if (size_ip < 6'(MIN_HDR_BYTES)) begin
      res.status = ST_BAD_IHL;
    end else if (ip_protocol_next == PROTO_TCP) begin
      if (rem < $signed((POS_W + 1)'(MIN_HDR_BYTES))) begin
        res.status = ST_L4_SHORT;
      end else if (tcp_hdr_len < 6'(MIN_HDR_BYTES)) begin
        res.status = ST_BAD_DOFF;
      end else begin
        // A TCP header longer than what is left clamps the length to zero.
        res.status         = ST_TCP;
        res.src_port       = held_src_port_next;
        res.dst_port       = held_dst_port_next;
        res.payload_offset = sat14(off_tcp);
        res.payload_length = sat14(plen_tcp);
      end
    end else if (eth && ip_protocol_next == PROTO_UDP) begin
      if (rem < $signed((POS_W + 1)'(UDP_HDR_BYTES))) begin
        res.status = ST_L4_SHORT;
      end else begin
        res.status         = ST_UDP;
        res.src_port       = held_src_port_next;
        res.dst_port       = held_dst_port_next;
        res.payload_offset = sat14(off_udp);
        res.payload_length = sat14(plen_udp);
      end
    end else if (eth) begin
      res.status         = ST_OTHER_IPV4;
      res.payload_offset = sat14(off_ip);
    end else begin
      res.status = ST_NOT_TCP_RAW;
    end
  end

  // ---- Packet state: advance per byte, clear after the last byte ----
  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      pos              <= '0;
      ether_kind       <= '0;
      ip_header_words  <= '0;
      ip_protocol      <= '0;
      held_source_ip   <= '0;
      held_dest_ip     <= '0;
      held_src_port    <= '0;
      held_dst_port    <= '0;
      tcp_offset_words <= '0;
    end else if (accept) begin
      pos              <= pos_next;
      ether_kind       <= ether_kind_next;
      ip_header_words  <= ip_header_words_next;
      ip_protocol      <= ip_protocol_next;
      held_source_ip   <= held_source_ip_next;
      held_dest_ip     <= held_dest_ip_next;
      held_src_port    <= held_src_port_next;
      held_dst_port    <= held_dst_port_next;
      tcp_offset_words <= tcp_offset_words_next;
    end
  end

  // ---- Result queue: output register plus skid entry ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (accept && item.last_byte) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= accept && item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !result_ready) begin
      if (accept && item.last_byte) begin
        skid <= res;
      end
    end else if (skid_valid) begin
      result <= skid;
    end else if (accept && item.last_byte) begin
      result <= res;
    end
  end

  // ---- Assertions ----
  `HP_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, result_valid,
                  "skid entry held while output register empty")
  `HP_ASSERT_NEXT(a_stall_to_skid, clk, rst,
                  accept && item.last_byte && result_valid && !result_ready,
                  skid_valid, "result lost while output stalled")
  `HP_ASSERT_NEXT(a_clear_after_last, clk, rst, accept && item.last_byte,
                  pos == '0, "byte position not cleared after last byte")
  `HP_ASSERT_IMPL(a_pos_bound, clk, rst, 1'b1, int'(pos) <= MAX_PACKET_BYTES,
                  "byte position beyond maximum packet size")

endmodule

// File: tb/eth_ipv4_l4_header_parser_tb.sv
// Self-checking testbench for the Ethernet/IPv4 TCP/UDP header parser.
`timescale 1ns / 100ps

module eth_ipv4_l4_header_parser_tb;
  import ip4hp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Raw IPv4 framing; the package only names the Ethernet setting.
  localparam logic LINK_RAW = 1'b1;

  // Register map: link_type at index 0; index 1 is unmapped and must be ignored.
  localparam logic [2:0] LINK_TYPE_ADDR = {REG_LINK_TYPE, 2'b00};
  localparam logic [2:0] SPARE_REG_ADDR = 3'd4;

  // Bytes of random traffic per phase, and the fewest packets per phase.
  localparam int PHASE_BYTES   = 40;
  localparam int PHASE_PACKETS = 2;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       req_item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     hdr_result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  eth_ipv4_l4_header_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (req_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (hdr_result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  item_t   byte_stream[$];       // bytes waiting to be offered to the parser
  result_t predicted_headers[$]; // parse results still owed by the DUT
  int      queued_bytes = 0;
  int      mismatch_count = 0;
  int      send_idle_pct = 0;    // chance (percent) the driver holds off a cycle
  int      recv_stall_pct = 0;   // chance (percent) result_ready is low

  // Predictor copy of the parser: link mode plus per-packet capture registers.
  logic        link_mode = LINK_ETH;
  int          seen_bytes = 0;   // saturates at MAX_PACKET_BYTES
  logic [15:0] cur_etype = '0;
  logic [3:0]  cur_ihl = '0;
  logic [7:0]  cur_proto = '0;
  logic [31:0] cur_src_ip = '0;
  logic [31:0] cur_dst_ip = '0;
  logic [15:0] cur_src_port = '0;
  logic [15:0] cur_dst_port = '0;
  logic [3:0]  cur_doff = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40) begin
      $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Clamp a signed position into a 14-bit result field.
  function automatic logic [13:0] clamp_field(input int v);
    logic [13:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > FIELD14_MAX) begin
      r = 14'(FIELD14_MAX);
    end else begin
      r = 14'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: fold one accepted byte into the capture registers. On the last
  // byte, classify the packet and queue the expected result, then clear.
  // ---------------------------------------------------------------------------
  task automatic parse_byte(input item_t it);
    result_t r;
    logic [7:0] b;
    bit eth, show_ip, show_ports;
    int base, pos, l4, len, ip_len, rem, tcp_len, off, plen;
    b    = it.data_byte;
    eth  = (link_mode == LINK_ETH);
    base = eth ? ETH_HDR_BYTES : 0;
    pos  = seen_bytes;

    // Capture runs under the mode current for this byte. The ethertype slot
    // is fixed at 12/13 whatever the framing.
    if (pos == ETYPE_POS_HI || pos == ETYPE_POS_LO) cur_etype = {cur_etype[7:0], b};
    if (pos == base) cur_ihl = b[3:0];
    if (pos == base + IP_PROTO_OFS) cur_proto = b;
    if (pos >= base + IP_SRC_OFS && pos < base + IP_DST_OFS) begin
      cur_src_ip = {cur_src_ip[23:0], b};
    end
    if (pos >= base + IP_DST_OFS && pos < base + IP_ADDR_END) begin
      cur_dst_ip = {cur_dst_ip[23:0], b};
    end
    // Transport offset uses the IHL as it stands after this byte.
    l4 = base + 4 * int'(cur_ihl);
    if (pos >= l4 && pos < l4 + L4_DPORT_OFS) cur_src_port = {cur_src_port[7:0], b};
    if (pos >= l4 + L4_DPORT_OFS && pos < l4 + L4_PORT_END) begin
      cur_dst_port = {cur_dst_port[7:0], b};
    end
    if (pos == l4 + TCP_DOFF_OFS) cur_doff = b[7:4];
    if (seen_bytes < MAX_PACKET_BYTES) seen_bytes++;

    if (it.last_byte) begin
      show_ip    = 1'b0;
      show_ports = 1'b0;
      off        = 0;
      plen       = 0;
      len        = seen_bytes;
      // Priority: truncated, short frame, ethertype, IHL, then protocol.
      if (it.truncated) begin
        r.status = ST_TRUNCATED;
      end else if (eth && len < ETH_HDR_BYTES) begin
        r.status = ST_SHORT_FRAME;
      end else if (eth && cur_etype != IPV4_KIND) begin
        r.status = ST_NOT_IPV4;
      end else begin
        show_ip = 1'b1;
        ip_len  = 4 * int'(cur_ihl);
        if (ip_len < MIN_HDR_BYTES) begin
          r.status = ST_BAD_IHL;
        end else begin
          // Signed: a packet ending inside the IP header goes negative.
          rem = len - base - ip_len;
          if (cur_proto == PROTO_TCP) begin
            tcp_len = 4 * int'(cur_doff);
            if (rem < MIN_HDR_BYTES) begin
              r.status = ST_L4_SHORT;
            end else if (tcp_len < MIN_HDR_BYTES) begin
              r.status = ST_BAD_DOFF;
            end else begin
              r.status   = ST_TCP;
              show_ports = 1'b1;
              off        = base + ip_len + tcp_len;
              plen       = rem - tcp_len;  // clamps to 0 when header overruns
            end
          end else if (eth && cur_proto == PROTO_UDP) begin
            if (rem < UDP_HDR_BYTES) begin
              r.status = ST_L4_SHORT;
            end else begin
              r.status   = ST_UDP;
              show_ports = 1'b1;
              off        = base + ip_len + UDP_HDR_BYTES;
              plen       = rem - UDP_HDR_BYTES;
            end
          end else if (eth) begin
            r.status = ST_OTHER_IPV4;
            off      = base + ip_len;
          end else begin
            r.status = ST_NOT_TCP_RAW;
          end
        end
      end
      r.source_ip      = show_ip ? cur_src_ip : '0;
      r.dest_ip        = show_ip ? cur_dst_ip : '0;
      r.src_port       = show_ports ? cur_src_port : '0;
      r.dst_port       = show_ports ? cur_dst_port : '0;
      r.payload_offset = clamp_field(off);
      r.payload_length = clamp_field(plen);
      predicted_headers.push_back(r);

      seen_bytes   = 0;
      cur_etype    = '0;
      cur_ihl      = '0;
      cur_proto    = '0;
      cur_src_ip   = '0;
      cur_dst_ip   = '0;
      cur_src_port = '0;
      cur_dst_port = '0;
      cur_doff     = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, holding off at random. valid stays up with a
  // stable payload until the byte is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_item   <= byte_stream.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result-side back pressure.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted byte, then checks every accepted result
  // against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (item_valid && item_ready) parse_byte(req_item);
      if (result_valid && result_ready) begin
        if (predicted_headers.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(hdr_result.status), '0);
        end else begin
          want = predicted_headers.pop_front();
          if (hdr_result.status !== want.status) begin
            report_mismatch("status", 32'(hdr_result.status), 32'(want.status));
          end
          if (hdr_result.source_ip !== want.source_ip) begin
            report_mismatch("source_ip", hdr_result.source_ip, want.source_ip);
          end
          if (hdr_result.dest_ip !== want.dest_ip) begin
            report_mismatch("dest_ip", hdr_result.dest_ip, want.dest_ip);
          end
          if (hdr_result.src_port !== want.src_port) begin
            report_mismatch("src_port", 32'(hdr_result.src_port), 32'(want.src_port));
          end
          if (hdr_result.dst_port !== want.dst_port) begin
            report_mismatch("dst_port", 32'(hdr_result.dst_port), 32'(want.dst_port));
          end
          if (hdr_result.payload_offset !== want.payload_offset) begin
            report_mismatch("payload_offset", 32'(hdr_result.payload_offset),
                            32'(want.payload_offset));
          end
          if (hdr_result.payload_length !== want.payload_length) begin
            report_mismatch("payload_length", 32'(hdr_result.payload_length),
                            32'(want.payload_length));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // APB access: setup phase, then access phase until pready.
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("link_type readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only legal while the parser is idle; upper data bits are don't-care.
  task automatic set_link_type(input logic mode);
    apb_write(LINK_TYPE_ADDR, {31'($urandom), mode});
    link_mode = mode;
    apb_read_check(LINK_TYPE_ADDR, {31'b0, mode});
  endtask

  // ---------------------------------------------------------------------------
  // Packet construction
  // ---------------------------------------------------------------------------
  function automatic int header_bytes(input bit raw, input logic [3:0] ihl,
                                      input logic [7:0] proto, input logic [3:0] doff);
    int n;
    n = (raw ? 0 : ETH_HDR_BYTES) + 4 * int'(ihl);
    if (proto == PROTO_TCP) begin
      n += 4 * int'(doff);
    end else if (proto == PROTO_UDP) begin
      n += UDP_HDR_BYTES;
    end
    return n;
  endfunction

  // Build a packet of len bytes (random, or all equal to fill when fill >= 0)
  // and plant ethertype, IHL, protocol and data offset where they fit. Bytes
  // other than the last carry a random truncated flag, which must be ignored.
  task automatic queue_packet(input bit raw, input int len, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [3:0] doff, input bit trunc, input int fill);
    byte_q_t q;
    item_t   it;
    int      base, l4;
    base = raw ? 0 : ETH_HDR_BYTES;
    l4   = base + 4 * int'(ihl);
    for (int i = 0; i < len; i++) q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if (!raw && len > ETYPE_POS_LO) begin
      q[ETYPE_POS_HI] = etype[15:8];
      q[ETYPE_POS_LO] = etype[7:0];
    end
    if (len > base) q[base] = {q[base][7:4], ihl};
    if (len > base + IP_PROTO_OFS) q[base + IP_PROTO_OFS] = proto;
    if (len > l4 + TCP_DOFF_OFS) q[l4 + TCP_DOFF_OFS] = {doff, q[l4 + TCP_DOFF_OFS][3:0]};
    foreach (q[i]) begin
      it.data_byte = q[i];
      it.last_byte = (i == len - 1);
      it.truncated = it.last_byte ? trunc : 1'($urandom);
      byte_stream.push_back(it);
    end
    queued_bytes += len;
  endtask

  // Mostly well-formed headers with random content; the rest are clipped
  // packets, runts and pure noise.
  task automatic queue_random_packet(input bit raw);
    int          pick, len;
    logic [15:0] etype;
    logic [3:0]  ihl, doff;
    logic [7:0]  proto;
    pick  = $urandom_range(99);
    etype = IPV4_KIND;
    ihl   = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    doff  = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    case ($urandom_range(3))
      0, 1: proto = PROTO_TCP;
      2: proto = PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    if (pick < 60) begin
      len = header_bytes(raw, ihl, proto, doff) + $urandom_range(0, 24);
    end else if (pick < 70) begin
      // cut short somewhere in the headers
      len = header_bytes(raw, ihl, proto, doff) - $urandom_range(1, 12);
      if (len < 1) len = 1;
    end else if (pick < 80) begin
      // runts: results back to back, fills the result queue under stall
      len = $urandom_range(1, 3);
    end else begin
      ihl  = 4'($urandom);
      doff = 4'($urandom);
      if ($urandom_range(1)) etype = 16'($urandom);
      len  = $urandom_range(1, 90);
    end
    queue_packet(raw, len, etype, ihl, proto, doff, ($urandom_range(19) == 0), -1);
  endtask

  // Wait until every byte is taken and every result checked, then let the
  // parser settle before any register write. Sampled mid-cycle so the
  // updates of the last edge have all landed.
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_stream.size() != 0 || item_valid || predicted_headers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input bit raw, input int idle, input int stall);
    int start, packets;
    send_idle_pct  <= idle;
    recv_stall_pct <= stall;
    start   = queued_bytes;
    packets = 0;
    while (queued_bytes - start < PHASE_BYTES || packets < PHASE_PACKETS) begin
      queue_random_packet(raw);
      packets++;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register setup; a write to the unmapped slot must leave link_type alone.
    set_link_type(LINK_ETH);
    apb_write(SPARE_REG_ADDR, 32'($urandom) | 32'h1);
    apb_read_check(LINK_TYPE_ADDR, {31'b0, LINK_ETH});

    // Directed Ethernet packets, no idling.
    queue_packet(0, header_bytes(0, 5, PROTO_TCP, 5) + 10, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1);
    // longest IP and TCP headers, empty payload
    queue_packet(0, header_bytes(0, 15, PROTO_TCP, 15), IPV4_KIND, 15, PROTO_TCP, 15, 0, -1);
    // all-ones and all-zeros addresses and ports
    queue_packet(0, header_bytes(0, 5, PROTO_TCP, 5) + 4, IPV4_KIND, 5, PROTO_TCP, 5, 0, 'hFF);
    queue_packet(0, header_bytes(0, 5, PROTO_TCP, 5) + 4, IPV4_KIND, 5, PROTO_TCP, 5, 0, 0);
    queue_packet(0, header_bytes(0, 5, PROTO_UDP, 0), IPV4_KIND, 5, PROTO_UDP, 0, 0, -1);
    queue_packet(0, header_bytes(0, 7, PROTO_UDP, 0) + 20, IPV4_KIND, 7, PROTO_UDP, 0, 0, -1);
    queue_packet(0, header_bytes(0, 5, 8'd1, 0) + 8, IPV4_KIND, 5, 8'd1, 0, 0, -1);
    queue_packet(0, header_bytes(0, 5, 8'hFF, 0), IPV4_KIND, 5, 8'hFF, 0, 0, -1);
    queue_packet(0, header_bytes(0, 5, PROTO_TCP, 5) + 6, IPV4_KIND, 5, PROTO_TCP, 5, 1, -1);
    queue_packet(0, 1, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1);            // single-byte runt
    queue_packet(0, ETH_HDR_BYTES - 1, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1);
    queue_packet(0, 60, 16'h86DD, 5, PROTO_TCP, 5, 0, -1);            // IPv6 ethertype
    queue_packet(0, 60, IPV4_KIND, 0, PROTO_TCP, 5, 0, -1);           // IHL zero
    queue_packet(0, ETH_HDR_BYTES, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1); // no IP bytes at all
    queue_packet(0, ETH_HDR_BYTES + 3, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1); // ends before proto
    queue_packet(0, ETH_HDR_BYTES + 39, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1); // TCP one short
    queue_packet(0, ETH_HDR_BYTES + 40, IPV4_KIND, 15, PROTO_TCP, 5, 0, -1); // negative remainder
    queue_packet(0, ETH_HDR_BYTES + 27, IPV4_KIND, 5, PROTO_UDP, 0, 0, -1); // UDP one short
    queue_packet(0, ETH_HDR_BYTES + 50, IPV4_KIND, 5, PROTO_TCP, 4, 0, -1); // data offset 16
    queue_packet(0, ETH_HDR_BYTES + 50, IPV4_KIND, 5, PROTO_TCP, 15, 0, -1); // header overruns
    wait_drained();

    random_phase(0, 0, 0);
    random_phase(0, 78, 0);
    random_phase(0, 0, 78);
    random_phase(0, 27, 27);

    // Raw IPv4: directed set first, then random.
    set_link_type(LINK_RAW);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    queue_packet(1, header_bytes(1, 5, PROTO_TCP, 5) + 5, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1);
    queue_packet(1, header_bytes(1, 6, PROTO_TCP, 6), IPV4_KIND, 6, PROTO_TCP, 6, 0, -1);
    queue_packet(1, 28, IPV4_KIND, 5, PROTO_UDP, 0, 0, -1);           // UDP refused in raw
    queue_packet(1, 40, IPV4_KIND, 5, 8'd1, 0, 0, -1);
    queue_packet(1, 40, IPV4_KIND, 3, PROTO_TCP, 5, 0, -1);           // bad IHL
    queue_packet(1, 39, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1);           // TCP one short
    queue_packet(1, 50, IPV4_KIND, 5, PROTO_TCP, 2, 0, -1);           // bad data offset
    queue_packet(1, 1, IPV4_KIND, 5, PROTO_TCP, 5, 0, -1);            // no short-frame check
    queue_packet(1, 44, IPV4_KIND, 5, PROTO_TCP, 5, 1, -1);
    wait_drained();

    random_phase(1, 0, 0);
    random_phase(1, 78, 0);
    random_phase(1, 0, 78);
    random_phase(1, 27, 27);

    // Back to Ethernet to check the mode switch in that direction.
    set_link_type(LINK_ETH);
    random_phase(0, 27, 27);

    repeat (8) @(posedge clk);
    if (predicted_headers.size() != 0) begin
      report_mismatch("results never delivered", 32'(predicted_headers.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog that fires far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
